>>> sv/bsp_pkg.sv
package bsp_pkg;

   // Framing and CRC constants of the configuration stream.
   localparam logic [31:0] SYNC_WORD = 32'h7EAA997E;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] CRC_TOP   = 16'h8000;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [3:0]  NIBBLE    = 4'hF;

   // Request command codes.
   localparam logic [1:0] CMD_DATA    = 2'd0;
   localparam logic [1:0] CMD_END     = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // Stream opcodes (high nibble of a command byte).
   localparam logic [3:0] OP_CTRL      = 4'd0;
   localparam logic [3:0] OP_PASS1     = 4'd1;
   localparam logic [3:0] OP_CRC_CHECK = 4'd2;
   localparam logic [3:0] OP_PASS5     = 4'd5;
   localparam logic [3:0] OP_WIDTH     = 4'd6;
   localparam logic [3:0] OP_HEIGHT    = 4'd7;
   localparam logic [3:0] OP_PASS8     = 4'd8;
   localparam logic [3:0] OP_PASS9     = 4'd9;

   // Arguments of the control opcode.
   localparam logic [31:0] CTL_CRAM      = 32'd1;
   localparam logic [31:0] CTL_BRAM      = 32'd3;
   localparam logic [31:0] CTL_CRC_RESET = 32'd5;
   localparam logic [31:0] CTL_WAKEUP    = 32'd6;

   // Reported status codes.
   localparam logic [3:0] ST_SEEK        = 4'd0;
   localparam logic [3:0] ST_PARSE       = 4'd1;
   localparam logic [3:0] ST_DONE        = 4'd2;
   localparam logic [3:0] ST_ERR_OPCODE  = 4'd3;
   localparam logic [3:0] ST_ERR_ARG     = 4'd4;
   localparam logic [3:0] ST_ERR_CRC     = 4'd5;
   localparam logic [3:0] ST_ERR_TRAILER = 4'd6;
   localparam logic [3:0] ST_ERR_WAKEUP  = 4'd7;
   localparam logic [3:0] ST_ERR_TRUNC   = 4'd8;

   // Register word index of the configuration port.
   localparam logic REG_FORWARD_ENABLE = 1'b0;

   // Parser phases, one-hot.
   typedef enum logic [13:0] {
      PH_SEEK        = 14'h0001,
      PH_CMD         = 14'h0002,
      PH_DONE        = 14'h0004,
      PH_ERR_OPCODE  = 14'h0008,
      PH_ERR_ARG     = 14'h0010,
      PH_ERR_CRC     = 14'h0020,
      PH_ERR_TRAILER = 14'h0040,
      PH_ERR_WAKEUP  = 14'h0080,
      PH_ERR_TRUNC   = 14'h0100,
      PH_ARGS        = 14'h0200,
      PH_DATA        = 14'h0400,
      PH_TRAIL1      = 14'h0800,
      PH_TRAIL2      = 14'h1000,
      PH_PAD         = 14'h2000
   } phase_type;

   // One result word of the parser.
   typedef struct packed {
      logic        send_valid;
      logic [7:0]  send_byte;
      logic [3:0]  status;
      logic [15:0] checksum;
   } result_type;

   // One CRC-16-CCITT step over a byte, MSB first.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic [15:0] v;
      c = crc;
      v = {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = ((c ^ v) & CRC_TOP) != 16'h0000 ? ((c << 1) ^ CRC_POLY) : (c << 1);
         v = v << 1;
      end
      return c;
   endfunction

   // Done and error phases ignore data until restart.
   function automatic logic phase_is_terminal(input phase_type ph);
      logic t;
      unique case (ph)
         PH_DONE, PH_ERR_OPCODE, PH_ERR_ARG, PH_ERR_CRC,
         PH_ERR_TRAILER, PH_ERR_WAKEUP, PH_ERR_TRUNC: t = 1'b1;
         default: t = 1'b0;
      endcase
      return t;
   endfunction

   // Status shown for a phase; the inner parsing phases all report parsing.
   function automatic logic [3:0] phase_status(input phase_type ph);
      logic [3:0] s;
      unique case (ph)
         PH_SEEK:        s = ST_SEEK;
         PH_DONE:        s = ST_DONE;
         PH_ERR_OPCODE:  s = ST_ERR_OPCODE;
         PH_ERR_ARG:     s = ST_ERR_ARG;
         PH_ERR_CRC:     s = ST_ERR_CRC;
         PH_ERR_TRAILER: s = ST_ERR_TRAILER;
         PH_ERR_WAKEUP:  s = ST_ERR_WAKEUP;
         PH_ERR_TRUNC:   s = ST_ERR_TRUNC;
         default:        s = ST_PARSE;
      endcase
      return s;
   endfunction

endpackage

>>> sv/fpga_bitstream_parser.sv
// An accepted request word passes the input register, then the response
// register. Throughput: one word per cycle unless a held response word
// stalls the request side; the CRC step and the command decode finish in
// the single logic stage between the two registers.
// Reset is synchronous and active high: the parser returns to sync hunting
// with the CRC at all ones, and forwarding is enabled.
module fpga_bitstream_parser
   import bsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_valid,
   output logic [7:0]  rsp_send_byte,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_checksum,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   result_type result_ff;
   result_type result;
   logic       out_free;
   logic       fire;
   logic       forward_enable;

   // The response register frees up when empty or when its word is taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // The idle command keeps the decoder on a known value before the first word.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_cmd_ff  <= CMD_UNUSED;
         in_byte_ff <= 8'd0;
      end else if (req_valid && !req_stall) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_data_byte;
      end
   end

   bsp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .forward_enable (forward_enable)
   );

   bsp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .cmd            (in_cmd_ff),
      .data_byte      (in_byte_ff),
      .forward_enable (forward_enable),
      .result         (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_send_valid = result_ff.send_valid;
   assign rsp_send_byte  = result_ff.send_byte;
   assign rsp_status     = result_ff.status;
   assign rsp_checksum   = result_ff.checksum;

   // The request side stalls only behind a held response word.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response word");

   // A processed word always shows up in the response register.
   assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed word lost before the response register");

   // A word waiting in the input register is not dropped.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("pending input word dropped");

endmodule

>>> sv/bsp_csr.sv
module bsp_csr
   import bsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic        forward_enable
);

   logic forward_enable_ff;
   logic forward_enable_in;
   logic write_hit;

   // A write lands in the access phase; words zero to three all hold the register.
   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_FORWARD_ENABLE);

   always_comb begin
      forward_enable_in = forward_enable_ff;
      if (write_hit) begin
         forward_enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_enable_ff <= 1'b1;
      end else begin
         forward_enable_ff <= forward_enable_in;
      end
   end

   // Read data returns the register, zero elsewhere.
   assign csr_prdata = (csr_paddr[2] == REG_FORWARD_ENABLE) ?
                       {31'b0, forward_enable_ff} : 32'b0;
   assign forward_enable = forward_enable_ff;

endmodule

>>> sv/bsp_parser.sv
module bsp_parser
   import bsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [1:0] cmd,
   input  logic [7:0] data_byte,
   input  logic       forward_enable,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [31:0] sync_ff, sync_in;
   logic [15:0] crc_ff, crc_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [3:0]  arg_left_ff, arg_left_in;
   logic [31:0] argument_ff, argument_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [31:0] data_left_ff, data_left_in;
   logic        last_check_ff, last_check_in;
   logic [31:0] product_ff;
   logic        terminal;
   logic        send;
   logic        exec;

   assign terminal = phase_is_terminal(phase_ff);

   // Next state for one word.
   always_comb begin
      phase_in      = phase_ff;
      sync_in       = sync_ff;
      crc_in        = crc_ff;
      opcode_in     = opcode_ff;
      arg_left_in   = arg_left_ff;
      argument_in   = argument_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      data_left_in  = data_left_ff;
      last_check_in = last_check_ff;
      send          = 1'b0;
      exec          = 1'b0;
      unique case (cmd)
         CMD_DATA: begin
            if (!terminal) begin
               crc_in = crc_step(crc_ff, data_byte);
               send   = forward_enable;
               unique case (phase_ff)
                  PH_SEEK: begin
                     sync_in = {sync_ff[23:0], data_byte};
                     if (sync_in == SYNC_WORD) begin
                        phase_in = PH_CMD;
                     end
                  end
                  PH_CMD: begin
                     opcode_in   = data_byte[7:4];
                     arg_left_in = data_byte[3:0] & NIBBLE;
                     argument_in = 32'd0;
                     if (arg_left_in == 4'd0) begin
                        exec = 1'b1;
                     end else begin
                        phase_in = PH_ARGS;
                     end
                  end
                  PH_ARGS: begin
                     argument_in = {argument_ff[23:0], data_byte};
                     arg_left_in = arg_left_ff - 4'd1;
                     if (arg_left_in == 4'd0) begin
                        exec = 1'b1;
                     end
                  end
                  PH_DATA: begin
                     data_left_in = data_left_ff - 32'd1;
                     if (data_left_in == 32'd0) begin
                        phase_in = PH_TRAIL1;
                     end
                  end
                  PH_TRAIL1: begin
                     phase_in = (data_byte == 8'd0) ? PH_TRAIL2 : PH_ERR_TRAILER;
                  end
                  PH_TRAIL2: begin
                     phase_in = (data_byte == 8'd0) ? PH_CMD : PH_ERR_TRAILER;
                  end
                  PH_PAD: begin
                     phase_in = PH_DONE;
                  end
                  default: begin
                  end
               endcase

               // Execute a command once its last argument byte is in, or at once if it has none.
               if (exec) begin
                  phase_in = PH_CMD;
                  unique case (opcode_in)
                     OP_PASS1, OP_PASS5, OP_PASS8, OP_PASS9: begin
                     end
                     OP_CRC_CHECK: begin
                        if (crc_in != 16'd0) begin
                           phase_in = PH_ERR_CRC;
                        end
                     end
                     OP_WIDTH: begin
                        width_in = argument_in + 32'd1;
                     end
                     OP_HEIGHT: begin
                        height_in = argument_in;
                     end
                     OP_CTRL: begin
                        priority if (argument_in == CTL_CRAM || argument_in == CTL_BRAM) begin
                           data_left_in = product_ff >> 3;
                           phase_in = (data_left_in != 32'd0) ? PH_DATA : PH_TRAIL1;
                        end else if (argument_in == CTL_CRC_RESET) begin
                           crc_in = CRC_INIT;
                        end else if (argument_in == CTL_WAKEUP) begin
                           phase_in = last_check_ff ? PH_PAD : PH_ERR_WAKEUP;
                        end else begin
                           phase_in = PH_ERR_ARG;
                        end
                     end
                     default: begin
                        phase_in = PH_ERR_OPCODE;
                     end
                  endcase
                  last_check_in = (opcode_in == OP_CRC_CHECK);
               end
            end
         end
         CMD_END: begin
            priority if (phase_ff == PH_PAD) begin
               phase_in = PH_DONE;
            end else if (!terminal) begin
               phase_in = PH_ERR_TRUNC;
            end
         end
         CMD_RESTART: begin
            phase_in      = PH_SEEK;
            sync_in       = 32'd0;
            crc_in        = CRC_INIT;
            opcode_in     = 4'd0;
            arg_left_in   = 4'd0;
            argument_in   = 32'd0;
            width_in      = 32'd0;
            height_in     = 32'd0;
            data_left_in  = 32'd0;
            last_check_in = 1'b0;
         end
         CMD_UNUSED: begin
         end
      endcase
   end

   // Parser state advances once per processed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEEK;
         sync_ff       <= 32'd0;
         crc_ff        <= CRC_INIT;
         opcode_ff     <= 4'd0;
         arg_left_ff   <= 4'd0;
         argument_ff   <= 32'd0;
         width_ff      <= 32'd0;
         height_ff     <= 32'd0;
         data_left_ff  <= 32'd0;
         last_check_ff <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         sync_ff       <= sync_in;
         crc_ff        <= crc_in;
         opcode_ff     <= opcode_in;
         arg_left_ff   <= arg_left_in;
         argument_ff   <= argument_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         data_left_ff  <= data_left_in;
         last_check_ff <= last_check_in;
      end
   end

   // Section size is registered; a data command is at least two words after
   // the last width or height update, so the product is always settled.
   always_ff @(posedge clock) begin
      product_ff <= 32'(height_ff * width_ff);
   end

   assign result.send_valid = send;
   assign result.send_byte  = send ? data_byte : 8'd0;
   assign result.status     = phase_status(phase_in);
   assign result.checksum   = crc_in;

endmodule
